FILE: rtl/core/assert_macros.svh
// Assertion macros for the RTL of the classify and compare unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/core/fpcc_pkg.sv
// -----------------------------------------------------------------------------
// fpcc_pkg
// Types and constants shared by the floating-point classify and compare unit.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
package fpcc_pkg;
    localparam logic [2:0] CLS_NAN  = 3'd0;
    localparam logic [2:0] CLS_INF  = 3'd1;
    localparam logic [2:0] CLS_ZERO = 3'd2;
    localparam logic [2:0] CLS_SUB  = 3'd3;
    localparam logic [2:0] CLS_NORM = 3'd4;

    localparam logic [1:0] FN_CLASS = 2'd0;
    localparam logic [1:0] FN_PRED  = 2'd1;
    localparam logic [1:0] FN_SIGN  = 2'd2;
    localparam logic [1:0] FN_CMP   = 2'd3;

    localparam logic [2:0] OP_FINITE = 3'd0;
    localparam logic [2:0] OP_INF    = 3'd1;
    localparam logic [2:0] OP_NAN    = 3'd2;
    localparam logic [2:0] OP_UNORD  = 3'd0;
    localparam logic [2:0] OP_GT     = 3'd1;
    localparam logic [2:0] OP_GE     = 3'd2;
    localparam logic [2:0] OP_LT     = 3'd3;
    localparam logic [2:0] OP_LE     = 3'd4;

    // Decoded operand after stage one.
    typedef struct packed {
        logic        neg;
        logic [62:0] mag;
        logic [2:0]  cls;
    } t_view;

    // Control carried alongside the data.
    typedef struct packed {
        logic [1:0] func;
        logic [2:0] op;
    } t_ctrl;

    // Ordering of x against y, with the sign and class of x, after stage two.
    typedef struct packed {
        logic any_nan;
        logic lt;
        logic eq;
        logic x_neg;
        logic [2:0] x_cls;
    } t_rel;
endpackage

FILE: rtl/core/fpcc_decode.sv
// -----------------------------------------------------------------------------
// fpcc_decode
// Stage one: splits both operands into sign, magnitude and class.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
module fpcc_decode (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic                 i_single_prec,
    input  fpcc_pkg::t_ctrl      i_ctrl,
    input  logic [63:0]          i_x_bits,
    input  logic [63:0]          i_y_bits,
    output logic                 o_valid,
    output fpcc_pkg::t_ctrl      o_ctrl,
    output fpcc_pkg::t_view      o_x,
    output fpcc_pkg::t_view      o_y
);
    logic            r_valid;
    fpcc_pkg::t_ctrl r_ctrl;
    fpcc_pkg::t_view r_x, r_y, n_x, n_y;

    function automatic fpcc_pkg::t_view f_decode(input logic [63:0] b, input logic sp);
        fpcc_pkg::t_view v;
        logic exp_ones, exp_zero, frac_nz;
        if (sp) begin
            v.neg    = b[31];
            v.mag    = {32'd0, b[30:0]};
            exp_ones = &b[30:23];
            exp_zero = ~|b[30:23];
            frac_nz  = |b[22:0];
        end else begin
            v.neg    = b[63];
            v.mag    = b[62:0];
            exp_ones = &b[62:52];
            exp_zero = ~|b[62:52];
            frac_nz  = |b[51:0];
        end
        if (exp_ones) begin
            v.cls = frac_nz ? fpcc_pkg::CLS_NAN : fpcc_pkg::CLS_INF;
        end else if (exp_zero) begin
            v.cls = frac_nz ? fpcc_pkg::CLS_SUB : fpcc_pkg::CLS_ZERO;
        end else begin
            v.cls = fpcc_pkg::CLS_NORM;
        end
        return v;
    endfunction

    // Decode both operands.
    always_comb begin
        n_x = f_decode(i_x_bits, i_single_prec);
        n_y = f_decode(i_y_bits, i_single_prec);
    end

    // Valid bit is control state; payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_ctrl <= i_ctrl;
        r_x    <= n_x;
        r_y    <= n_y;
    end

    assign o_valid = r_valid;
    assign o_ctrl  = r_ctrl;
    assign o_x     = r_x;
    assign o_y     = r_y;
endmodule

FILE: rtl/core/fpcc_relate.sv
// -----------------------------------------------------------------------------
// fpcc_relate
// Stage two: works out the ordering of x against y.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
module fpcc_relate (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  fpcc_pkg::t_ctrl i_ctrl,
    input  fpcc_pkg::t_view i_x,
    input  fpcc_pkg::t_view i_y,
    output logic            o_valid,
    output fpcc_pkg::t_ctrl o_ctrl,
    output fpcc_pkg::t_rel  o_rel
);
    logic            r_valid;
    fpcc_pkg::t_ctrl r_ctrl;
    fpcc_pkg::t_rel  r_rel, n_rel;
    logic            mag_lt, mag_eq;

    // Wide compares of the magnitudes, then sign handling.
    always_comb begin
        mag_lt = i_x.mag < i_y.mag;
        mag_eq = i_x.mag == i_y.mag;
        n_rel.any_nan = (i_x.cls == fpcc_pkg::CLS_NAN) || (i_y.cls == fpcc_pkg::CLS_NAN);
        n_rel.x_neg   = i_x.neg;
        n_rel.x_cls   = i_x.cls;
        priority if ((i_x.mag == '0) && (i_y.mag == '0)) begin
            n_rel.eq = 1'b1;
            n_rel.lt = 1'b0;
        end else if (i_x.neg != i_y.neg) begin
            n_rel.eq = 1'b0;
            n_rel.lt = i_x.neg;
        end else begin
            n_rel.eq = mag_eq;
            n_rel.lt = !mag_eq && (i_x.neg ? !mag_lt : mag_lt);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_ctrl <= i_ctrl;
        r_rel  <= n_rel;
    end

    assign o_valid = r_valid;
    assign o_ctrl  = r_ctrl;
    assign o_rel   = r_rel;
endmodule

FILE: rtl/core/fpcc_select.sv
// -----------------------------------------------------------------------------
// fpcc_select
// Stage three: picks the flag that the function and op ask for.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
module fpcc_select (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  fpcc_pkg::t_ctrl i_ctrl,
    input  fpcc_pkg::t_rel  i_rel,
    output logic            o_valid,
    output logic [2:0]      o_class_code,
    output logic            o_flag
);
    logic       r_valid, r_flag, n_flag, pred, cmp;
    logic [2:0] r_class;

    // Class predicate.
    always_comb begin
        unique case (i_ctrl.op)
            fpcc_pkg::OP_FINITE: pred = (i_rel.x_cls != fpcc_pkg::CLS_INF) &&
                                        (i_rel.x_cls != fpcc_pkg::CLS_NAN);
            fpcc_pkg::OP_INF:    pred = i_rel.x_cls == fpcc_pkg::CLS_INF;
            fpcc_pkg::OP_NAN:    pred = i_rel.x_cls == fpcc_pkg::CLS_NAN;
            default:             pred = i_rel.x_cls == fpcc_pkg::CLS_NORM;
        endcase
    end

    // Comparison; a NaN operand only satisfies the unordered test.
    always_comb begin
        if (i_rel.any_nan) begin
            cmp = i_ctrl.op == fpcc_pkg::OP_UNORD;
        end else begin
            unique case (i_ctrl.op)
                fpcc_pkg::OP_UNORD: cmp = 1'b0;
                fpcc_pkg::OP_GT:    cmp = !i_rel.lt && !i_rel.eq;
                fpcc_pkg::OP_GE:    cmp = !i_rel.lt;
                fpcc_pkg::OP_LT:    cmp = i_rel.lt;
                fpcc_pkg::OP_LE:    cmp = i_rel.lt || i_rel.eq;
                default:            cmp = !i_rel.eq;
            endcase
        end
    end

    always_comb begin
        unique case (i_ctrl.func)
            fpcc_pkg::FN_CLASS: n_flag = 1'b0;
            fpcc_pkg::FN_PRED:  n_flag = pred;
            fpcc_pkg::FN_SIGN:  n_flag = i_rel.x_neg;
            default:            n_flag = cmp;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_flag  <= n_flag;
        r_class <= i_rel.x_cls;
    end

    assign o_valid      = r_valid;
    assign o_class_code = r_class;
    assign o_flag       = r_flag;
endmodule

FILE: rtl/core/fp_classify_compare_unit.sv
// -----------------------------------------------------------------------------
// fp_classify_compare_unit
// Classifies, tests and compares IEEE-754 single or double bit patterns.
// -----------------------------------------------------------------------------
// Channel   Direction  Handshake              Payload
// command   in         start && !busy         func, single_prec, op, x_bits, y_bits
// result    out        o_done (one cycle)     class_code, flag
//
// Each transaction passes through the stages decode, magnitude compare and flag select, in that order.
// One transaction is accepted every cycle; busy is never raised.
// Synchronous reset clears the stage valid bits only.
// The receiver cannot stall, so the pipeline never holds.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fp_classify_compare_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_func,
    input  logic        i_single_prec,
    input  logic [2:0]  i_op,
    input  logic [63:0] i_x_bits,
    input  logic [63:0] i_y_bits,
    output logic        o_done,
    output logic [2:0]  o_class_code,
    output logic        o_flag
);
    logic            accept, s1_valid, s2_valid;
    fpcc_pkg::t_ctrl in_ctrl, s1_ctrl, s2_ctrl;
    fpcc_pkg::t_view s1_x, s1_y;
    fpcc_pkg::t_rel  s2_rel;

    assign busy    = 1'b0;
    assign accept  = start && !busy;
    assign in_ctrl = '{func: i_func, op: i_op};

    fpcc_decode u_decode (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(accept),
        .i_single_prec(i_single_prec), .i_ctrl(in_ctrl),
        .i_x_bits(i_x_bits), .i_y_bits(i_y_bits),
        .o_valid(s1_valid), .o_ctrl(s1_ctrl), .o_x(s1_x), .o_y(s1_y)
    );

    fpcc_relate u_relate (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(s1_valid),
        .i_ctrl(s1_ctrl), .i_x(s1_x), .i_y(s1_y),
        .o_valid(s2_valid), .o_ctrl(s2_ctrl), .o_rel(s2_rel)
    );

    fpcc_select u_select (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(s2_valid),
        .i_ctrl(s2_ctrl), .i_rel(s2_rel),
        .o_valid(o_done), .o_class_code(o_class_code), .o_flag(o_flag)
    );

    // Every accepted transaction passes stage one and stage two and comes out on o_done.
    `ASSERT_NEXT(a_stage1, i_clk, i_rst_n, accept, s1_valid)
    `ASSERT_NEXT(a_stage2, i_clk, i_rst_n, s1_valid, s2_valid)
    `ASSERT_IMPL(a_latency, i_clk, i_rst_n, o_done == $past(accept, 3))
    // A classify transaction always reports a clear flag.
    `ASSERT_IMPL(a_class_flag, i_clk, i_rst_n,
        (o_done && $past(i_func, 3) == fpcc_pkg::FN_CLASS) |-> !o_flag)
endmodule

FILE: dv/fpcc_result_checker.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// fpcc_result_checker
// Watches the command and result channels of the classify and compare unit,
// works out the class code and flag of every accepted command and compares
// each result with the oldest outstanding expectation.
// -----------------------------------------------------------------------------
module fpcc_result_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [1:0]  i_func,
    input  logic        i_single_prec,
    input  logic [2:0]  i_op,
    input  logic [63:0] i_x_bits,
    input  logic [63:0] i_y_bits,
    input  logic        i_done,
    input  logic [2:0]  i_class_code,
    input  logic        i_flag,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_results_seen
);

    typedef struct packed {
        logic [2:0] class_code;
        logic       flag;
    } t_outcome;

    typedef struct packed {
        logic        neg;
        logic [62:0] mag;
        logic [2:0]  cls;
    } t_operand;

    t_outcome outcome_queue[$];

    initial begin
        o_fail_count   = 0;
        o_results_seen = 0;
    end

    assign o_pending = outcome_queue.size();

    // Splits a pattern into sign, magnitude and class at the chosen precision.
    function automatic t_operand decode_operand(logic [63:0] bits, logic sp);
        t_operand   d;
        logic       frac_nz;
        logic       exp_ones;
        logic       exp_zero;
        if (sp) begin
            d.neg    = bits[31];
            d.mag    = {32'd0, bits[30:0]};
            exp_ones = &bits[30:23];
            exp_zero = ~|bits[30:23];
            frac_nz  = |bits[22:0];
        end else begin
            d.neg    = bits[63];
            d.mag    = bits[62:0];
            exp_ones = &bits[62:52];
            exp_zero = ~|bits[62:52];
            frac_nz  = |bits[51:0];
        end
        if (exp_ones) d.cls = frac_nz ? fpcc_pkg::CLS_NAN : fpcc_pkg::CLS_INF;
        else if (exp_zero) d.cls = frac_nz ? fpcc_pkg::CLS_SUB : fpcc_pkg::CLS_ZERO;
        else d.cls = fpcc_pkg::CLS_NORM;
        return d;
    endfunction

    // Works out the result that one command should produce.
    function automatic t_outcome compute_outcome(logic [1:0] func, logic sp,
                                                 logic [2:0] op,
                                                 logic [63:0] xb, logic [63:0] yb);
        t_operand x;
        t_operand y;
        t_outcome r;
        logic     lt;
        logic     eq;
        x = decode_operand(xb, sp);
        y = decode_operand(yb, sp);
        r.class_code = x.cls;
        r.flag = 1'b0;
        case (func)
            fpcc_pkg::FN_PRED: begin
                case (op)
                    fpcc_pkg::OP_FINITE: r.flag = (x.cls != fpcc_pkg::CLS_INF) &&
                                                  (x.cls != fpcc_pkg::CLS_NAN);
                    fpcc_pkg::OP_INF:    r.flag = (x.cls == fpcc_pkg::CLS_INF);
                    fpcc_pkg::OP_NAN:    r.flag = (x.cls == fpcc_pkg::CLS_NAN);
                    default:             r.flag = (x.cls == fpcc_pkg::CLS_NORM);
                endcase
            end
            fpcc_pkg::FN_SIGN: r.flag = x.neg;
            fpcc_pkg::FN_CMP: begin
                if (x.cls == fpcc_pkg::CLS_NAN || y.cls == fpcc_pkg::CLS_NAN) begin
                    r.flag = (op == fpcc_pkg::OP_UNORD);
                end else begin
                    // Signed zeros are equal; otherwise order by sign, then magnitude.
                    if (x.mag == 0 && y.mag == 0) begin
                        eq = 1'b1; lt = 1'b0;
                    end else if (x.neg != y.neg) begin
                        eq = 1'b0; lt = x.neg;
                    end else if (x.mag == y.mag) begin
                        eq = 1'b1; lt = 1'b0;
                    end else begin
                        eq = 1'b0;
                        lt = x.neg ? (x.mag > y.mag) : (x.mag < y.mag);
                    end
                    case (op)
                        fpcc_pkg::OP_UNORD: r.flag = 1'b0;
                        fpcc_pkg::OP_GT:    r.flag = !lt && !eq;
                        fpcc_pkg::OP_GE:    r.flag = !lt;
                        fpcc_pkg::OP_LT:    r.flag = lt;
                        fpcc_pkg::OP_LE:    r.flag = lt || eq;
                        default:            r.flag = !eq;
                    endcase
                end
            end
            default: r.flag = 1'b0;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what);
        $display("[%0t] MISMATCH: %s", $time, what);
        o_fail_count++;
    endtask

    // Records expectations for accepted commands and checks each result.
    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && i_done) begin
            o_results_seen++;
            if (outcome_queue.size() == 0) begin
                report_mismatch("result with no command outstanding");
            end else begin
                want = outcome_queue.pop_front();
                if (i_class_code !== want.class_code)
                    report_mismatch($sformatf("class_code got %0d want %0d",
                                              i_class_code, want.class_code));
                if (i_flag !== want.flag)
                    report_mismatch($sformatf("flag got %b want %b", i_flag, want.flag));
            end
        end
        if (i_rst_n && i_start && !i_busy)
            outcome_queue.push_back(compute_outcome(i_func, i_single_prec, i_op,
                                                    i_x_bits, i_y_bits));
    end

endmodule

FILE: dv/fp_classify_compare_unit_test.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// fp_classify_compare_unit_test
// Drives directed and random commands into the classify and compare unit under
// several idling phases; a checker module predicts and compares every result.
// -----------------------------------------------------------------------------
module fp_classify_compare_unit_test;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  func;
    logic        single_prec;
    logic [2:0]  op;
    logic [63:0] x_bits;
    logic [63:0] y_bits;
    logic        done;
    logic [2:0]  class_code;
    logic        flag;
    logic        stim_done;
    int          fail_count;
    int          pending;
    int          results_seen;
    int          idle_pct;

    fp_classify_compare_unit i_dut (
        .i_clk(clk), .i_rst_n(rst_n), .start(start), .busy(busy),
        .i_func(func), .i_single_prec(single_prec), .i_op(op),
        .i_x_bits(x_bits), .i_y_bits(y_bits),
        .o_done(done), .o_class_code(class_code), .o_flag(flag)
    );

    fpcc_result_checker i_checker (
        .i_clk(clk), .i_rst_n(rst_n), .i_start(start), .i_busy(busy),
        .i_func(func), .i_single_prec(single_prec), .i_op(op),
        .i_x_bits(x_bits), .i_y_bits(y_bits),
        .i_done(done), .i_class_code(class_code), .i_flag(flag),
        .o_fail_count(fail_count), .o_pending(pending),
        .o_results_seen(results_seen)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Builds a pattern of a chosen class; sp selects single precision layout.
    function automatic logic [63:0] make_operand(logic [2:0] cls, logic sp);
        logic [63:0] b;
        b = {$urandom, $urandom};
        if (sp) begin
            case (cls)
                fpcc_pkg::CLS_NAN:  begin
                    b[30:23] = '1;
                    if (b[22:0] == 0) b[0] = 1'b1;
                end
                fpcc_pkg::CLS_INF:  begin b[30:23] = '1; b[22:0] = '0; end
                fpcc_pkg::CLS_ZERO: b[30:0] = '0;
                fpcc_pkg::CLS_SUB:  begin
                    b[30:23] = '0;
                    if (b[22:0] == 0) b[22] = 1'b1;
                end
                default:  if (&b[30:23] || ~|b[30:23]) b[30:23] = 8'h7e;
            endcase
        end else begin
            case (cls)
                fpcc_pkg::CLS_NAN:  begin
                    b[62:52] = '1;
                    if (b[51:0] == 0) b[51] = 1'b1;
                end
                fpcc_pkg::CLS_INF:  begin b[62:52] = '1; b[51:0] = '0; end
                fpcc_pkg::CLS_ZERO: b[62:0] = '0;
                fpcc_pkg::CLS_SUB:  begin
                    b[62:52] = '0;
                    if (b[51:0] == 0) b[0] = 1'b1;
                end
                default:  if (&b[62:52] || ~|b[62:52]) b[62:52] = 11'h3ff;
            endcase
        end
        return b;
    endfunction

    // Presents one command and holds it until the unit takes it.
    task automatic send_command(logic [1:0] f, logic sp, logic [2:0] o,
                                logic [63:0] xb, logic [63:0] yb);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge clk);
        end
        start       <= 1'b1;
        func        <= f;
        single_prec <= sp;
        op          <= o;
        x_bits      <= xb;
        y_bits      <= yb;
        @(posedge clk);
        while (busy) @(posedge clk);
        @(negedge clk);
    endtask

    // Random command; y is often close to x so that equality is exercised.
    task automatic send_random();
        logic        sp;
        logic [63:0] xb;
        logic [63:0] yb;
        sp = 1'($urandom_range(1));
        xb = $urandom_range(3) == 0 ? {$urandom, $urandom}
                                    : make_operand(3'($urandom_range(4)), sp);
        case ($urandom_range(3))
            0: yb = xb;
            1: yb = xb ^ (64'd1 << $urandom_range(sp ? 31 : 63));
            2: yb = {$urandom, $urandom};
            default: yb = make_operand(3'($urandom_range(4)), sp);
        endcase
        send_command(2'($urandom_range(3)), sp, 3'($urandom_range(7)), xb, yb);
    endtask

    initial begin
        int n;
        start       = 1'b0;
        stim_done   = 1'b0;
        func        = fpcc_pkg::FN_CLASS;
        single_prec = 1'b0;
        op          = fpcc_pkg::OP_FINITE;
        x_bits      = '0;
        y_bits      = '0;
        idle_pct    = 0;
        rst_n       = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: each class in both precisions, each function and op.
        for (int c = 0; c <= 4; c++) begin
            send_command(fpcc_pkg::FN_CLASS, 1'b0, 3'd7, make_operand(3'(c), 1'b0), '1);
            send_command(fpcc_pkg::FN_CLASS, 1'b1, 3'd0, make_operand(3'(c), 1'b1), '0);
        end
        for (int o = 0; o < 8; o++) begin
            send_command(fpcc_pkg::FN_PRED, o[0], 3'(o), make_operand(3'(o % 5), o[0]), '0);
            send_command(fpcc_pkg::FN_CMP, 1'b0, 3'(o), 64'h8000_0000_0000_0000, '0);
        end
        send_command(fpcc_pkg::FN_SIGN, 1'b0, 3'd0, '1, '0);
        send_command(fpcc_pkg::FN_SIGN, 1'b1, 3'd0, 64'h0000_0000_8000_0000, '1);
        send_command(fpcc_pkg::FN_CMP, 1'b1, fpcc_pkg::OP_UNORD,
                     make_operand(fpcc_pkg::CLS_NAN, 1'b1), 64'd0);
        send_command(fpcc_pkg::FN_CMP, 1'b0, 3'd5, 64'd1,
                     make_operand(fpcc_pkg::CLS_NAN, 1'b0));

        // Random phases of sender idling: none, light, heavy, then light again.
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = (ph == 0) ? 0 : (ph == 1) ? 36 : (ph == 2) ? 86 : 36;
            n = (ph == 2) ? 250 : 425;
            repeat (n) send_random();
        end
        start     <= 1'b0;
        stim_done <= 1'b1;
    end

    // Ends the run once every command has produced its result.
    initial begin
        wait (stim_done);
        @(negedge clk);
        wait (pending == 0);
        repeat (10) @(posedge clk);
        $display("Ran %0d results over all classes, functions and ops, both precisions,",
                 results_seen);
        $display("with sender idling phases of 0, 36 and 86 percent.");
        if (fail_count == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #2000000;
        $display("Timeout");
        $display("Mismatches found");
        $finish;
    end

endmodule

FILE: fp_classify_compare_unit.f
+incdir+rtl/core
rtl/core/fpcc_pkg.sv
rtl/core/fpcc_decode.sv
rtl/core/fpcc_relate.sv
rtl/core/fpcc_select.sv
rtl/core/fp_classify_compare_unit.sv
dv/fpcc_result_checker.sv
dv/fp_classify_compare_unit_test.sv
